// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands for the tokenizer rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define LFT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lft assertion failed");

// next-cycle implication, held off during reset
`define LFT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lft assertion failed");

`endif

// File: src/lft_pkg.sv
// ---------------------------------------------------------------------------
// lft_pkg
// types, character codes and keyword tables for the formula tokenizer
// ---------------------------------------------------------------------------
`default_nettype none

package lft_pkg;

    localparam int unsigned MAX_POSITION_DEF = 65535;

    localparam int CH_W  = 8;
    localparam int POS_W = 16;
    localparam int LEN_W = 16;

    // result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_NOT     = 4'd2,
        K_AND     = 4'd3,
        K_OR      = 4'd4,
        K_XOR     = 4'd5,
        K_IMPLIES = 4'd6,
        K_IFF     = 4'd7,
        K_SET     = 4'd8,
        K_TRUE    = 4'd9,
        K_FALSE   = 4'd10,
        K_IDENT   = 4'd11,
        K_ILLEGAL = 4'd12,
        K_EOF     = 4'd13
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_MINUS   = 3'd2,
        M_LT      = 3'd3,
        M_LTMINUS = 3'd4
    } t_mode;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   tok_pos;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_tok;

    // tokens produced by one byte, first in tok_a
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok_a;
        t_tok       tok_b;
    } t_push;

    typedef struct packed {
        t_mode              mode;
        logic [POS_W-1:0]   pos;
    } t_core_stat;

    typedef struct packed {
        logic               room;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_AMP    = 8'h26;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [CH_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [CH_W-1:0] CH_TILDE  = 8'h7E;

    // keyword index: 0 SET, 1 true, 2 false
    localparam int         KW_N         = 3;
    localparam logic [2:0] KW_FLAGS_ALL = 3'b111;

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] idx);
        logic [2:0] len;
        unique case (idx)
            2'd0:    len = 3'd3;
            2'd1:    len = 3'd4;
            2'd2:    len = 3'd5;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_kind kw_kind(input logic [1:0] idx);
        t_kind k;
        unique case (idx)
            2'd0:    k = K_SET;
            2'd1:    k = K_TRUE;
            2'd2:    k = K_FALSE;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    // letter of a keyword at a position, zero past its end
    function automatic logic [CH_W-1:0] kw_char(input logic [1:0] idx, input logic [2:0] at);
        logic [CH_W-1:0] c;
        c = CH_NUL;
        unique case ({idx, at})
            {2'd0, 3'd0}: c = "S";
            {2'd0, 3'd1}: c = "E";
            {2'd0, 3'd2}: c = "T";
            {2'd1, 3'd0}: c = "t";
            {2'd1, 3'd1}: c = "r";
            {2'd1, 3'd2}: c = "u";
            {2'd1, 3'd3}: c = "e";
            {2'd2, 3'd0}: c = "f";
            {2'd2, 3'd1}: c = "a";
            {2'd2, 3'd2}: c = "l";
            {2'd2, 3'd3}: c = "s";
            {2'd2, 3'd4}: c = "e";
            default:      c = CH_NUL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/lft_core.sv
// ---------------------------------------------------------------------------
// lft_core
// lexer state and per-byte decode: closes pending tokens, opens new ones
// ---------------------------------------------------------------------------
`default_nettype none

module lft_core import lft_pkg::*; #(
    parameter int unsigned MAX_POSITION = MAX_POSITION_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [CH_W-1:0]  i_ch,
    output t_push                 o_push,
    output t_core_stat            o_stat
);

    localparam logic [POS_W-1:0] POS_CAP =
        (MAX_POSITION < ((2 ** POS_W) - 1)) ? POS_W'(MAX_POSITION) : '1;

    t_mode              r_mode,      n_mode;
    logic [POS_W-1:0]   r_tok_start, n_tok_start;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic [2:0]         r_kw_flags,  n_kw_flags;
    logic [LEN_W-1:0]   r_run_len,   n_run_len;

    // letter append, either continuing a run or starting one
    logic [2:0]         al_flags_in;
    logic [LEN_W-1:0]   al_run_in;
    logic [2:0]         al_keep;
    logic [2:0]         al_flags;
    logic [LEN_W-1:0]   al_run;

    always_comb begin
        al_flags_in = (r_mode == M_IDENT) ? r_kw_flags : KW_FLAGS_ALL;
        al_run_in   = (r_mode == M_IDENT) ? r_run_len  : '0;
        for (int i = 0; i < KW_N; i++) begin
            al_keep[i] = al_flags_in[i]
                       && (al_run_in < LEN_W'(kw_len(2'(i))))
                       && (kw_char(2'(i), al_run_in[2:0]) == i_ch);
        end
        if (al_run_in != '1) begin
            al_run   = al_run_in + LEN_W'(1);
            al_flags = al_keep;
        end else begin
            al_run   = al_run_in;
            al_flags = '0;
        end
    end

    // kind of the identifier run held in state
    t_kind ident_kind;

    always_comb begin
        ident_kind = K_IDENT;
        for (int i = KW_N - 1; i >= 0; i--) begin
            if (r_kw_flags[i] && (r_run_len == LEN_W'(kw_len(2'(i))))) begin
                ident_kind = kw_kind(2'(i));
            end
        end
    end

    logic alpha;
    logic used;
    logic has_pend;
    logic has_own;
    logic is_eof;
    t_tok tok_pend;
    t_tok tok_own;

    assign alpha = is_alpha(i_ch);

    always_comb begin
        used        = 1'b0;
        has_pend    = 1'b0;
        has_own     = 1'b0;
        is_eof      = 1'b0;
        tok_pend    = '{kind: K_ILLEGAL, tok_pos: r_tok_start, length: LEN_W'(1), last: 1'b0};
        tok_own     = '{kind: K_ILLEGAL, tok_pos: r_pos, length: LEN_W'(1), last: 1'b0};
        n_mode      = r_mode;
        n_tok_start = r_tok_start;
        n_kw_flags  = r_kw_flags;
        n_run_len   = r_run_len;

        // close or extend whatever is pending
        unique case (r_mode)
            M_IDENT: begin
                if (alpha) begin
                    used = 1'b1;
                end else begin
                    has_pend        = 1'b1;
                    tok_pend.kind   = ident_kind;
                    tok_pend.length = r_run_len;
                end
            end
            M_MINUS: begin
                has_pend = 1'b1;
                if (i_ch == CH_GT) begin
                    used            = 1'b1;
                    tok_pend.kind   = K_IMPLIES;
                    tok_pend.length = LEN_W'(2);
                end
            end
            M_LT: begin
                if (i_ch == CH_MINUS) begin
                    used = 1'b1;
                end else begin
                    has_pend = 1'b1;
                end
            end
            M_LTMINUS: begin
                has_pend = 1'b1;
                if (i_ch == CH_GT) begin
                    used            = 1'b1;
                    tok_pend.kind   = K_IFF;
                    tok_pend.length = LEN_W'(3);
                end else begin
                    tok_pend.length = LEN_W'(2);
                end
            end
            default: begin
            end
        endcase

        if (used) begin
            unique case (r_mode)
                M_LT:    n_mode = M_LTMINUS;
                M_IDENT: begin
                    n_mode     = M_IDENT;
                    n_kw_flags = al_flags;
                    n_run_len  = al_run;
                end
                default: n_mode = M_IDLE;
            endcase
        end else begin
            n_mode = M_IDLE;
            unique case (i_ch)
                CH_NUL: begin
                    is_eof         = 1'b1;
                    has_own        = 1'b1;
                    tok_own.kind   = K_EOF;
                    tok_own.length = '0;
                    n_tok_start    = '0;
                    n_kw_flags     = '0;
                    n_run_len      = '0;
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                end
                CH_LPAREN: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_LPAREN;
                end
                CH_RPAREN: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_RPAREN;
                end
                CH_TILDE: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_NOT;
                end
                CH_AMP: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_AND;
                end
                CH_BAR: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_OR;
                end
                CH_CARET: begin
                    has_own      = 1'b1;
                    tok_own.kind = K_XOR;
                end
                CH_MINUS: begin
                    n_mode      = M_MINUS;
                    n_tok_start = r_pos;
                end
                CH_LT: begin
                    n_mode      = M_LT;
                    n_tok_start = r_pos;
                end
                default: begin
                    if (alpha) begin
                        n_mode      = M_IDENT;
                        n_tok_start = r_pos;
                        n_kw_flags  = al_flags;
                        n_run_len   = al_run;
                    end else begin
                        has_own = 1'b1;
                    end
                end
            endcase
        end

        if (is_eof) begin
            n_pos = '0;
        end else if (r_pos < POS_CAP) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = POS_CAP;
        end
    end

    // pack the tokens, last on the final one
    always_comb begin
        o_push = '0;
        if (has_pend && has_own) begin
            o_push.cnt        = 2'd2;
            o_push.tok_a      = tok_pend;
            o_push.tok_b      = tok_own;
            o_push.tok_b.last = 1'b1;
        end else if (has_pend) begin
            o_push.cnt        = 2'd1;
            o_push.tok_a      = tok_pend;
            o_push.tok_a.last = 1'b1;
        end else if (has_own) begin
            o_push.cnt        = 2'd1;
            o_push.tok_a      = tok_own;
            o_push.tok_a.last = 1'b1;
        end
        if (!i_fire) begin
            o_push.cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_tok_start <= '0;
            r_pos       <= '0;
            r_kw_flags  <= '0;
            r_run_len   <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_tok_start <= n_tok_start;
            r_pos       <= n_pos;
            r_kw_flags  <= n_kw_flags;
            r_run_len   <= n_run_len;
        end
    end

    assign o_stat = '{mode: r_mode, pos: r_pos};

endmodule

`default_nettype wire

// File: src/lft_queue.sv
// ---------------------------------------------------------------------------
// lft_queue
// small result queue: takes up to two tokens a cycle, hands out one
// ---------------------------------------------------------------------------
`default_nettype none

module lft_queue import lft_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_tok        o_head,
    output t_q_stat     o_stat
);

    t_tok               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr,    n_wr;
    logic [Q_PTR_W-1:0] r_rd,    n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr + Q_PTR_W'(i_push.cnt);
        n_rd    = r_rd + Q_PTR_W'(i_pop);
        n_count = r_count + Q_CNT_W'(i_push.cnt) - Q_CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wr] <= i_push.tok_a;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[r_wr + Q_PTR_W'(1)] <= i_push.tok_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rd];
    // room for a worst-case two-token byte regardless of this cycle's pop
    assign o_stat  = '{room: (r_count <= Q_CNT_W'(Q_DEPTH - 2)), count: r_count};

endmodule

`default_nettype wire

// File: src/logic_formula_tokenizer.sv
// ---------------------------------------------------------------------------
// logic_formula_tokenizer
// streaming lexer for propositional formulas, one byte per beat in,
// one token per beat out
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  input    in         i_valid / o_stall       i_ch (byte, 0 ends the text)
//  output   out        o_valid / i_stall       o_kind o_tok_pos o_length o_last
//
//  a byte is taken into the input register, decoded against the lexer state
//  once the result queue has room, and its tokens are written into the queue
//  behind any tokens already waiting there
//  sustained rate is one byte per cycle while bytes yield at most one token
//  and i_stall is low; the output port moves one token per unstalled cycle,
//  so bytes that close a pending token and emit their own take two transfers
//  the four-entry result queue decouples the sides: a byte is decoded only
//  when two entries are free, so a stalled output fills the queue, then the
//  input register, then stalls the input
//  reset is synchronous; no clearing pass, the block takes bytes straight away
// ---------------------------------------------------------------------------
`default_nettype none

module logic_formula_tokenizer import lft_pkg::*; #(
    parameter int unsigned MAX_POSITION = MAX_POSITION_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input byte channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [CH_W-1:0]    i_ch,
    // token channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_kind,
    output logic [POS_W-1:0]        o_tok_pos,
    output logic [LEN_W-1:0]        o_length,
    output logic                    o_last
);

`include "assert_macros.svh"

    // input register
    logic               r_in_valid, n_in_valid;
    logic [CH_W-1:0]    r_in_ch;

    logic               in_beat;
    logic               fire;
    logic               pop;

    t_push              push;
    t_core_stat         core_stat;
    t_q_stat            q_stat;
    t_tok               q_head;

    // end of text decoded, and the lexer sitting at its start
    logic               eof_fire;
    logic               core_home;

    // decode a held byte only when the queue can absorb two tokens
    assign fire    = r_in_valid && q_stat.room;
    // input register frees up in the same cycle that its byte is decoded
    assign o_stall = r_in_valid && !fire;
    assign in_beat = i_valid && !o_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // byte payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_ch <= i_ch;
        end
    end

    // lexer state and per-byte decode
    lft_core #(
        .MAX_POSITION (MAX_POSITION)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (r_in_ch),
        .o_push  (push),
        .o_stat  (core_stat)
    );

    // result queue doubles as the output register
    assign pop = o_valid && !i_stall;

    lft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    assign o_kind    = q_head.kind;
    assign o_tok_pos = q_head.tok_pos;
    assign o_length  = q_head.length;
    assign o_last    = q_head.last;

    assign eof_fire  = fire && (r_in_ch == CH_NUL);
    assign core_home = (core_stat.pos == '0) && (core_stat.mode == M_IDLE);

    // queue never overfills
    `LFT_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
    // end of text puts the lexer back at position zero, nothing pending
    `LFT_ASSERT_NXT(a_eof_restart, i_clk, i_rst_n, eof_fire, core_home)
    // a decoded byte with tokens shows a token on the next cycle
    `LFT_ASSERT_NXT(a_push_shows, i_clk, i_rst_n, push.cnt != 2'd0, o_valid)

endmodule

`default_nettype wire
